[design/mieu_pkg.sv]
// package for the integer execute unit: opcodes, function codes, states, command structs
// no dependencies
package mieu_pkg;

  localparam int unsigned DMEM_WORDS_DEF = 4096;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_SYS = 2'd2;

  localparam logic [31:0] SYSCALL_WORD = 32'h0000_000C;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_BASE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_MEM, S_STORE, S_WB, S_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;   // write zero to the next memory row
    logic load_instr; // capture instruction
    logic read_regs;  // register the operands
    logic decode;     // evaluate the instruction, latch result
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic mem_read;   // register the word(s) for the access
    logic mem_write;  // write one word of a store
    logic commit;     // update architectural state and output register
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic need_mul;
    logic need_div;
    logic need_mem;
    logic is_store;
    logic mul_done;
    logic div_done;
    logic store_done;
  } dp_stat_t;

endpackage

[design/mieu_ctrl.sv]
// controller for the integer execute unit: sequences clear pass, fetch, execute and output
// depends on mieu_pkg
module mieu_ctrl
  import mieu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_busy,
  input  dp_stat_t stat,
  output logic     idle,
  output logic     out_load,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load_instr = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read_regs = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.decode = 1'b1;
        if (stat.need_mul) begin
          cmd.mul_start = 1'b1;
          state_next = S_MUL;
        end else if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else if (stat.need_mem) begin
          state_next = S_MEM;
        end else begin
          state_next = S_WB;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_WB;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_WB;
      end
      S_MEM: begin
        cmd.mem_read = 1'b1;
        state_next = stat.is_store ? S_STORE : S_WB;
      end
      S_STORE: begin
        cmd.mem_write = 1'b1;
        if (stat.store_done) state_next = S_WB;
      end
      S_WB: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  as_clear_first: assert property (@(posedge clk) $past(rst) && !rst |-> state != S_IDLE)
    else $error("left clear pass too early");
  as_no_load_busy: assert property (@(posedge clk) disable iff (rst) out_load |-> !out_busy)
    else $error("output overwritten");
  as_idle_only_take: assert property (@(posedge clk) disable iff (rst)
    cmd.load_instr |-> idle) else $error("item taken while busy");

endmodule

[design/mieu_dp.sv]
// datapath for the integer execute unit: register file, hi/lo, pc, data memory,
// alu, shared iterative multiply/divide unit; depends on mieu_pkg
module mieu_dp
  import mieu_pkg::*;
#(
  parameter int unsigned DMEM_WORDS = DMEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [31:0] instr_in,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  output logic [1:0]  r_status,
  output logic [31:0] r_next_pc,
  output logic        r_we,
  output logic [4:0]  r_idx,
  output logic [31:0] r_val
);

  localparam int unsigned AW = $clog2(DMEM_WORDS);
  localparam logic [32:0] LIMIT = 33'(DMEM_WORDS) << 2;

  logic [31:0] regs [32];
  logic [31:0] mem  [DMEM_WORDS];
  logic [31:0] pc, hi, lo, base;
  logic [31:0] ir, a, b;
  logic [AW:0] clr_cnt;

  wire [5:0]  op  = ir[31:26];
  wire [4:0]  rs  = ir[25:21];
  wire [4:0]  rt  = ir[20:16];
  wire [4:0]  rd  = ir[15:11];
  wire [4:0]  sa  = ir[10:6];
  wire [5:0]  fn  = ir[5:0];
  wire [15:0] imm = ir[15:0];
  wire [31:0] simm = {{16{imm[15]}}, imm};

  // latched decode
  logic        err, wr, sys, set_hi, set_lo;
  logic [4:0]  dst;
  logic [31:0] val, npc, nhi, nlo;
  logic        is_mul, is_div, is_mem, is_st;
  logic [1:0]  size_m1;
  logic [31:0] off;

  // combinational decode
  logic        e_err, e_wr, e_sys, e_shi, e_slo, e_mul, e_div, e_mem, e_st, e_sgn;
  logic [4:0]  e_dst;
  logic [31:0] e_val, e_npc, e_nhi, e_nlo, e_off;
  logic [1:0]  e_sz;
  logic [31:0] addr, tgt, jtgt;
  logic [32:0] room;

  always_comb begin
    addr = a + simm;
    tgt  = pc + (simm << 2);
    jtgt = {pc[31:28] + 4'(pc[27:2] == 26'h3FFFFFF), ir[25:0], 2'b00};
    e_err = 1'b0; e_wr = 1'b0; e_sys = 1'b0; e_shi = 1'b0; e_slo = 1'b0;
    e_mul = 1'b0; e_div = 1'b0; e_mem = 1'b0; e_st = 1'b0; e_sgn = 1'b0;
    e_dst = rt; e_val = '0; e_npc = pc + 32'd4; e_nhi = a; e_nlo = a; e_sz = 2'd0;
    e_off = addr - base;
    room = '0;
    if (ir == SYSCALL_WORD) begin
      e_sys = 1'b1;
    end else if (op == OP_SPECIAL) begin
      e_wr = 1'b1;
      e_dst = rd;
      case (fn)
        FN_SLL: e_val = b << sa;
        FN_SRL: e_val = b >> sa;
        FN_SRA: e_val = $unsigned($signed(b) >>> sa);
        FN_JR: begin e_wr = 1'b0; e_npc = a; end
        FN_MFHI: e_val = hi;
        FN_MTHI: begin e_wr = 1'b0; e_shi = 1'b1; end
        FN_MFLO: e_val = lo;
        FN_MTLO: begin e_wr = 1'b0; e_slo = 1'b1; end
        FN_MULT, FN_MULTU: begin
          e_wr = 1'b0; e_mul = 1'b1; e_sgn = (fn == FN_MULT);
        end
        FN_DIV, FN_DIVU: begin
          e_wr = 1'b0;
          if (b == '0) e_err = 1'b1;
          else begin e_div = 1'b1; e_sgn = (fn == FN_DIV); end
        end
        FN_ADD, FN_ADDU: e_val = a + b;
        FN_SUB, FN_SUBU: e_val = a - b;
        FN_AND: e_val = a & b;
        FN_OR:  e_val = a | b;
        FN_XOR: e_val = a ^ b;
        FN_NOR: e_val = ~(a | b);
        FN_SLT: e_val = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: e_val = {31'd0, a < b};
        default: e_err = 1'b1;
      endcase
    end else begin
      case (op)
        OP_REGIMM: begin
          if (rt == 5'd0) begin if (a[31]) e_npc = tgt; end
          else if (rt == 5'd1) begin if (!a[31]) e_npc = tgt; end
          else e_err = 1'b1;
        end
        OP_J: e_npc = jtgt;
        OP_JAL: begin e_wr = 1'b1; e_dst = 5'd31; e_val = pc + 32'd4; e_npc = jtgt; end
        OP_BEQ:  if (a == b) e_npc = tgt;
        OP_BNE:  if (a != b) e_npc = tgt;
        OP_BLEZ: if ($signed(a) < 32'sd1) e_npc = tgt;
        OP_BGTZ: if ($signed(a) > 32'sd0) e_npc = tgt;
        OP_ADDI, OP_ADDIU: begin e_wr = 1'b1; e_val = a + simm; end
        OP_SLTI:  begin e_wr = 1'b1; e_val = {31'd0, $signed(a) < $signed(simm)}; end
        OP_SLTIU: begin e_wr = 1'b1; e_val = {31'd0, a < simm}; end
        OP_ANDI: begin e_wr = 1'b1; e_val = a & {16'd0, imm}; end
        OP_ORI:  begin e_wr = 1'b1; e_val = a | {16'd0, imm}; end
        OP_LUI:  begin e_wr = 1'b1; e_val = {imm, 16'd0}; end
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_SB, OP_SH, OP_SW: begin
          e_sz = (op == OP_LW || op == OP_SW) ? 2'd3 :
                 (op == OP_LH || op == OP_SH) ? 2'd1 : 2'd0;
          room = {1'b0, e_off} + {31'd0, e_sz};
          if (room >= LIMIT) e_err = 1'b1;
          else begin
            e_mem = 1'b1;
            e_st = (op == OP_SB || op == OP_SH || op == OP_SW);
            e_wr = !e_st;
          end
        end
        default: e_err = 1'b1;
      endcase
    end
    if (e_err) begin
      e_wr = 1'b0; e_mul = 1'b0; e_div = 1'b0; e_mem = 1'b0; e_shi = 1'b0; e_slo = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_instr) ir <= instr_in;
    if (cmd.read_regs) begin
      a <= regs[rs];
      b <= regs[rt];
    end
    if (cmd.decode) begin
      err <= e_err; wr <= e_wr; sys <= e_sys; set_hi <= e_shi; set_lo <= e_slo;
      dst <= e_dst; val <= e_val; npc <= e_npc; nhi <= e_nhi; nlo <= e_nlo;
      is_mul <= e_mul; is_div <= e_div; is_mem <= e_mem; is_st <= e_st;
      size_m1 <= e_sz; off <= e_off;
    end
  end

  // shared iterative unit: shift-add multiply and restoring divide, one bit per cycle
  logic [31:0] ma, mb, acc_lo, quo;
  logic [32:0] acc_hi;
  logic [5:0]  cnt;
  logic        nega, negb;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [32:0] trial;

  assign trial = {acc_hi[31:0], quo[31]} - {1'b0, mb};

  // start comes with decode, so the sign mode is taken from the live decode
  always_ff @(posedge clk) begin
    if (cmd.mul_start || cmd.div_start) begin
      nega <= e_sgn && a[31];
      negb <= e_sgn && b[31];
      ma <= (e_sgn && a[31]) ? 32'd0 - a : a;
      mb <= (e_sgn && b[31]) ? 32'd0 - b : b;
      acc_hi <= '0;
      acc_lo <= '0;
      quo <= (e_sgn && a[31]) ? 32'd0 - a : a;
      cnt <= '0;
    end else if (cmd.mul_step) begin
      // accumulate from the top bit down: acc = acc*2 + bit*mb
      {acc_hi, acc_lo} <= {acc_hi[31:0], acc_lo, 1'b0} + (ma[31] ? {33'd0, mb} : 65'd0);
      ma <= ma << 1;
      cnt <= cnt + 6'd1;
    end else if (cmd.div_step) begin
      if (!trial[32]) acc_hi <= {1'b0, trial[31:0]};
      else            acc_hi <= {1'b0, acc_hi[30:0], quo[31]};
      quo <= {quo[30:0], !trial[32]};
      cnt <= cnt + 6'd1;
    end
  end

  assign prod = (nega ^ negb) ? 64'd0 - {acc_hi[31:0], acc_lo} : {acc_hi[31:0], acc_lo};
  assign rem  = nega ? 32'd0 - acc_hi[31:0] : acc_hi[31:0];

  // memory access: up to two word rows, read, then written back for stores
  logic [AW-1:0] w0, w1;
  logic [31:0]   d0, d1;
  logic [63:0]   pair, wpair, bmask;
  logic [5:0]    bsh;
  logic          two, st_phase;
  logic [31:0]   ld;

  assign w0   = off[AW+1:2];
  assign w1   = w0 + AW'(1);
  assign bsh  = {off[1:0], 3'b000};
  assign two  = ({1'b0, off[1:0]} + {1'b0, size_m1}) > 3'd3;
  assign pair = {d1, d0} >> bsh;
  assign bmask = {32'd0, (size_m1 == 2'd3) ? 32'hFFFF_FFFF :
                         (size_m1 == 2'd1) ? 32'h0000_FFFF : 32'h0000_00FF} << bsh;
  assign wpair = ({d1, d0} & ~bmask) | (({32'd0, b} << bsh) & bmask);

  always_comb begin
    case (size_m1)
      2'd3:    ld = pair[31:0];
      2'd1:    ld = {{16{pair[15]}}, pair[15:0]};
      default: ld = (op == OP_LB) ? {{24{pair[7]}}, pair[7:0]} : {24'd0, pair[7:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_cnt[AW-1:0]] <= '0;
    else if (cmd.mem_write) mem[st_phase ? w1 : w0] <= st_phase ? wpair[63:32] : wpair[31:0];
    if (cmd.mem_read) begin
      d0 <= mem[w0];
      d1 <= mem[w1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      st_phase <= 1'b0;
    end else begin
      if (cmd.clr_step && !clr_cnt[AW]) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.mem_write) st_phase <= two && !st_phase;
    end
  end

  assign stat.clr_done   = clr_cnt == (AW+1)'(DMEM_WORDS - 1);
  assign stat.need_mul   = e_mul;
  assign stat.need_div   = e_div;
  assign stat.need_mem   = e_mem;
  assign stat.is_store   = is_st;
  assign stat.mul_done   = cnt == 6'd31 && cmd.mul_step;
  assign stat.div_done   = cnt == 6'd31 && cmd.div_step;
  assign stat.store_done = !two || st_phase;

  logic [31:0] fval;
  logic        fwe;
  assign fval = is_mem ? ld : val;
  assign fwe  = wr && dst != 5'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0; hi <= '0; lo <= '0; base <= '0;
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_START) pc <= cfg_data;
        else base <= cfg_data;
      end
      if (cmd.commit && !err) begin
        pc <= npc;
        if (set_hi) hi <= nhi;
        if (set_lo) lo <= nlo;
        if (is_mul) begin hi <= prod[63:32]; lo <= prod[31:0]; end
        if (is_div) begin
          hi <= rem;
          lo <= (nega ^ negb) ? 32'd0 - quo : quo;
        end
        if (fwe) regs[dst] <= fval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      r_status  <= err ? ST_ERR : sys ? ST_SYS : ST_OK;
      r_next_pc <= err ? pc : npc;
      r_we      <= fwe && !err;
      r_idx     <= (fwe && !err) ? dst : 5'd0;
      r_val     <= (fwe && !err) ? fval : 32'd0;
    end
  end

  as_reg0: assert property (@(posedge clk) disable iff (rst) regs[0] == 32'd0)
    else $error("register zero written");
  as_err_pc: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && err |=> pc == $past(pc)) else $error("pc moved on error");
  as_mem_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_read |-> !err) else $error("access outside window");

endmodule

[design/mips_integer_execute_unit.sv]
// top level of the integer execute unit: stream ports, config port, output register
// depends on mieu_pkg, mieu_ctrl, mieu_dp
//
// s_axis carries one instruction word per request in tdata[31:0]. m_axis returns one
// result per instruction: tdata = {reg_write_value, reg_write_index, reg_write_en,
// next_pc, status} from the top bit down, 72 bits. cfg writes index 0 (start address,
// also loads the pc) or index 1 (data window base); the user must write only when the
// unit is idle, which the unit itself does not enforce. A result passes the read,
// execute and write-back states; loads add a registered memory read, stores add a read
// and one write per word they touch, and mult/div iterate on the one-bit-per-cycle
// shared unit. One instruction is in flight at a time; the next is accepted once the
// result has left the output register, which holds it while m_axis_tready is low.
// After reset the data memory is zeroed by a pass over all DMEM_WORDS rows during
// which s_axis_tready stays low; config writes are taken throughout.
module mips_integer_execute_unit
  import mieu_pkg::*;
#(
  parameter int unsigned DMEM_WORDS = DMEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // instr_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // status, next_pc, reg_write_en, reg_write_index,
                                     // reg_write_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        idle, out_load, in_fire, cfg_we;
  logic [1:0]  st;
  logic [31:0] npc, val;
  logic        we;
  logic [4:0]  idx;

  assign s_axis_tready = idle && !m_axis_tvalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid;

  mieu_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_busy(m_axis_tvalid), .stat, .idle, .out_load, .cmd
  );

  mieu_dp #(.DMEM_WORDS(DMEM_WORDS)) u_dp (
    .clk, .rst, .cmd, .stat, .instr_in(s_axis_tdata),
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .r_status(st), .r_next_pc(npc), .r_we(we), .r_idx(idx), .r_val(val)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {val, idx, we, npc, st};

endmodule
